[rtl/lztd_pkg.sv]
// ----------------------------------------------------------------------------
// lztd_pkg
// Shared types and constants for the LZ77 token decoder.
// ----------------------------------------------------------------------------
package lztd_pkg;

  localparam int ByteW    = 8;
  localparam int OffW     = 16;
  localparam int LenW     = 8;
  localparam int OutBytes = 4;
  localparam int CountW   = 3;
  localparam int MaxRes   = 64;
  localparam int ResW     = 7;             // holds 0..MaxRes
  localparam int InDataW  = 32;            // four byte fields
  localparam int OutDataW = 40;            // 4 bytes + count, padded to 5 bytes
  localparam int FillW    = 2;             // fill index into the staging word

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ERROR
  } state_e;

  // one decoded byte, or an error marker, offered to the packer
  typedef struct packed {
    logic             valid;
    logic             err;
    logic             last;
    logic [ByteW-1:0] data;
  } pk_in_t;

endpackage

[rtl/lztd_history.sv]
// ----------------------------------------------------------------------------
// lztd_history
// History RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lztd_history #(
  parameter int DEPTH = 65536
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [lztd_pkg::ByteW-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [lztd_pkg::ByteW-1:0]    rdata_o
);

  logic [lztd_pkg::ByteW-1:0] mem [DEPTH];
  logic [lztd_pkg::ByteW-1:0] rdata_q;

  // read-during-write to one address returns the old byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lztd_packer.sv]
// ----------------------------------------------------------------------------
// lztd_packer
// Gathers decoded bytes into result words and holds the output register.
// ----------------------------------------------------------------------------
module lztd_packer #(
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lztd_pkg::pk_in_t                pk_i,
  output logic                            ready_o,
  input  logic                            m_tready_i,
  output logic                            m_tvalid_o,
  output logic [lztd_pkg::OutDataW-1:0]   m_tdata_o,
  output logic                            m_tlast_o,
  output logic                            m_tuser_o
);

  localparam int Per = (BYTES_PER_RESULT < 1) ? 1 :
                       (BYTES_PER_RESULT > lztd_pkg::OutBytes) ? lztd_pkg::OutBytes :
                       BYTES_PER_RESULT;

  logic [lztd_pkg::OutBytes-1:0][lztd_pkg::ByteW-1:0] acc_q;
  logic [lztd_pkg::FillW-1:0]  fill_q, fill_d;
  logic [lztd_pkg::ResW-1:0]   res_q, res_d;
  logic                        ovalid_q, ovalid_d;
  logic [lztd_pkg::OutBytes-1:0][lztd_pkg::ByteW-1:0] obytes_q, obytes_d;
  logic [lztd_pkg::CountW-1:0] ocount_q, ocount_d;
  logic                        olast_q, olast_d, oerr_q, oerr_d;

  logic [lztd_pkg::CountW-1:0] fill_plus;
  logic                        room, emit, load, take;

  assign fill_plus = lztd_pkg::CountW'(fill_q) + 1'b1;
  assign room      = res_q < lztd_pkg::ResW'(lztd_pkg::MaxRes);
  // an error word always emits; a byte emits when its group closes
  assign emit      = pk_i.err || pk_i.last || (fill_plus == lztd_pkg::CountW'(Per));
  assign ready_o   = !(emit && (room || pk_i.err) && ovalid_q && !m_tready_i);
  assign take      = pk_i.valid && ready_o;
  assign load      = take && emit && (room || pk_i.err);

  always_comb begin
    fill_d   = fill_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && !m_tready_i;
    obytes_d = obytes_q;
    ocount_d = ocount_q;
    olast_d  = olast_q;
    oerr_d   = oerr_q;
    if (take && !pk_i.err) begin
      if (emit) begin
        fill_d = '0;
        res_d  = pk_i.last ? '0 : (room ? res_q + 1'b1 : res_q);
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (load) begin
      ovalid_d = 1'b1;
      oerr_d   = pk_i.err;
      if (pk_i.err) begin
        obytes_d = '0;
        ocount_d = '0;
        olast_d  = 1'b1;
      end else begin
        for (int i = 0; i < lztd_pkg::OutBytes; i++) begin
          if (lztd_pkg::CountW'(i) >= fill_plus) begin
            obytes_d[i] = '0;
          end else if (lztd_pkg::FillW'(i) == fill_q) begin
            obytes_d[i] = pk_i.data;
          end else begin
            obytes_d[i] = acc_q[i];
          end
        end
        ocount_d = fill_plus;
        // the 64th result closes the token even if bytes remain
        olast_d  = pk_i.last || (res_q == lztd_pkg::ResW'(lztd_pkg::MaxRes - 1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      res_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      res_q    <= res_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !pk_i.err) begin
      acc_q[fill_q] <= pk_i.data;
    end
    obytes_q <= obytes_d;
    ocount_q <= ocount_d;
    olast_q  <= olast_d;
    oerr_q   <= oerr_d;
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = lztd_pkg::OutDataW'({ocount_q, obytes_q});
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = oerr_q;

endmodule

[rtl/lz77_token_decoder.sv]
// ----------------------------------------------------------------------------
// lz77_token_decoder
// LZ77 token decoder: back-reference copy from a history RAM plus a literal.
// ----------------------------------------------------------------------------
// Each input word is one token. The decoder copies match_length bytes from
// the history, starting offset bytes behind the write pointer, one byte per
// cycle through the history RAM unless the packer stalls, then appends the
// literal; every byte is written back to the history, so overlapping copies
// repeat bytes. Bytes are packed BYTES_PER_RESULT to an output word, the
// final word of a token carries tlast, and at most 64 words leave per token.
// A token with a nonzero length and an offset of zero or beyond the bytes
// seen since the last stream start yields a single error word (tuser high,
// count zero) and writes nothing to the history.
// The history RAM reads and writes one byte per cycle. A new token is taken
// only once the previous one has been fully handed to the output register,
// which can still hold the last word.
// ----------------------------------------------------------------------------
module lz77_token_decoder #(
  parameter int HISTORY_DEPTH    = 65536,
  parameter int MAX_MATCH        = 255,
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side: tokens
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] offset_high, [15:8] offset_low, [23:16] match_length,
  // [31:24] literal_byte
  input  logic [lztd_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] stream_start
  input  logic                          s_axis_tuser,
  // master side: decoded words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3,
  // [34:32] byte_count, [39:35] zero
  output logic [lztd_pkg::OutDataW-1:0] m_axis_tdata,
  // last_of_token
  output logic                          m_axis_tlast,
  // [0] bad_offset
  output logic                          m_axis_tuser
);

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int BWW = AW + 1;       // bytes_written, saturates at depth
  localparam int SW  = lztd_pkg::OffW + 1;

  // token fields
  logic [lztd_pkg::ByteW-1:0] off_hi, off_lo, lit_in;
  logic [lztd_pkg::LenW-1:0]  len_in, len_sat;
  logic [lztd_pkg::OffW-1:0]  off;
  assign off_hi = s_axis_tdata[7:0];
  assign off_lo = s_axis_tdata[15:8];
  assign len_in = s_axis_tdata[23:16];
  assign lit_in = s_axis_tdata[31:24];
  assign off    = {off_hi, off_lo};
  assign len_sat = (len_in > lztd_pkg::LenW'(MAX_MATCH)) ? lztd_pkg::LenW'(MAX_MATCH) : len_in;

  lztd_pkg::state_e state_q, state_d;

  logic [AW-1:0]  wp_q, wp_d, src_q, src_d;
  logic [BWW-1:0] bw_q, bw_d;
  logic [lztd_pkg::LenW-1:0] rem_q, rem_d;
  logic first_q, off1_q, p_q, p_d, pl_q, fwd_q;
  logic [lztd_pkg::ByteW-1:0] lit_q, last_q, rdata, cur_byte;

  logic in_acc, bad, issue, issue_rd, consume, pk_ready;
  logic [AW-1:0]  wp_eff;
  logic [BWW-1:0] bw_eff;
  logic [SW-1:0]  wp_w, off_w, src_w;
  lztd_pkg::pk_in_t pk_in;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // stream start resets the count before this token is checked
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign wp_eff = s_axis_tuser ? '0 : wp_q;
  assign bw_eff = s_axis_tuser ? '0 : bw_q;
  assign bad    = (len_sat != '0) && ((off == '0) || (SW'(off) > SW'(bw_eff)));

  // copy start, modulo depth; only used when the offset passed the check
  assign wp_w  = SW'(wp_eff);
  assign off_w = SW'(off);
  assign src_w = (wp_w >= off_w) ? wp_w - off_w : wp_w + SW'(HISTORY_DEPTH) - off_w;

  assign consume  = p_q && pk_ready;
  assign issue_rd = issue && (rem_q != '0);

  // offset one reads the address written this very cycle: take the byte held
  assign cur_byte = pl_q ? lit_q : (fwd_q ? last_q : rdata);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lztd_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = bad ? lztd_pkg::ST_ERROR : lztd_pkg::ST_RUN;
        end
      end
      lztd_pkg::ST_RUN: begin
        if (issue && (rem_q == '0)) begin
          state_d = lztd_pkg::ST_DRAIN;
        end
      end
      lztd_pkg::ST_DRAIN: begin
        if (consume) begin
          state_d = lztd_pkg::ST_IDLE;
        end
      end
      lztd_pkg::ST_ERROR: begin
        if (pk_ready) begin
          state_d = lztd_pkg::ST_IDLE;
        end
      end
      default: state_d = lztd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    pk_in.valid   = p_q;
    pk_in.err     = 1'b0;
    pk_in.last    = pl_q;
    pk_in.data    = cur_byte;
    unique case (state_q)
      lztd_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      lztd_pkg::ST_RUN:   issue = !p_q || pk_ready;
      lztd_pkg::ST_DRAIN: issue = 1'b0;
      lztd_pkg::ST_ERROR: begin
        pk_in.valid = 1'b1;
        pk_in.err   = 1'b1;
        pk_in.last  = 1'b1;
      end
      default: issue = 1'b0;
    endcase
  end

  // pointers and the single-byte pipe stage
  always_comb begin
    wp_d  = wp_q;
    bw_d  = bw_q;
    src_d = src_q;
    rem_d = rem_q;
    p_d   = p_q;
    if (in_acc && s_axis_tuser) begin
      wp_d = '0;
      bw_d = '0;
    end
    if (consume) begin
      wp_d = ptr_inc(wp_q);
      if (bw_q != BWW'(HISTORY_DEPTH)) begin
        bw_d = bw_q + 1'b1;
      end
    end
    if (in_acc) begin
      src_d = src_w[AW-1:0];
      rem_d = len_sat;
    end else if (issue_rd) begin
      src_d = ptr_inc(src_q);
      rem_d = rem_q - 1'b1;
    end
    if (issue) begin
      p_d = 1'b1;
    end else if (consume) begin
      p_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lztd_pkg::ST_IDLE;
      wp_q    <= '0;
      bw_q    <= '0;
      p_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      bw_q    <= bw_d;
      p_q     <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    rem_q <= rem_d;
    if (in_acc) begin
      lit_q   <= lit_in;
      off1_q  <= (off == lztd_pkg::OffW'(1));
      first_q <= 1'b1;
    end else if (issue_rd) begin
      first_q <= 1'b0;
    end
    if (issue) begin
      pl_q  <= (rem_q == '0);
      fwd_q <= !first_q && off1_q && (rem_q != '0);
    end
    if (consume) begin
      last_q <= cur_byte;
    end
  end

  lztd_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (consume),
    .waddr_i (wp_q),
    .wdata_i (cur_byte),
    .re_i    (issue_rd),
    .raddr_i (src_q),
    .rdata_o (rdata)
  );

  lztd_packer #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pk_i       (pk_in),
    .ready_o    (pk_ready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

[rtl/lztd_checker.sv]
// ----------------------------------------------------------------------------
// lztd_checker
// Port-level checks for the LZ77 token decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lztd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lztd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser
);

  // a held word does not change until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // one token at a time: no acceptance right after one
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("token accepted while previous one in progress");

  // error word is empty and closes the token
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("malformed error word");

  // data word carries one to four bytes
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[34:32] != 3'd0)
      && (m_axis_tdata[34:32] <= 3'd4))
    else $error("byte count out of range");

  // a word with one byte reads zero in the upper byte lanes
  a_zero_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[34:32] == 3'd1) |-> (m_axis_tdata[31:8] == '0))
    else $error("stale byte beyond count");

endmodule

bind lz77_token_decoder lztd_checker u_lztd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
